FILE: rtl/hpn_pkg.sv
// shared types, constants and base-patch table for the neighbour index pipeline
package hpn_pkg;

  localparam int IdxW     = 42;
  localparam int LvlW     = 5;
  localparam int MaxLevel = 19;
  localparam int CoordW   = MaxLevel;
  localparam int BaseW    = 4;
  localparam int NumDir   = 4;
  localparam int ShW      = LvlW + 1;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [LvlW-1:0]   lvl_t;
  typedef logic [CoordW-1:0] coord_t;
  typedef logic [BaseW-1:0]  base_t;

  // step directions in output order
  typedef enum logic [1:0] {
    DirNe,
    DirNw,
    DirSw,
    DirSe
  } dir_e;

  // north row is 0..3, south row is 8..11
  localparam base_t LastNorth  = base_t'(3);
  localparam base_t FirstSouth = base_t'(8);
  localparam base_t LastBase   = base_t'(11);

  typedef struct packed {
    logic valid;
    logic invalid;
    lvl_t level;
  } ctl_t;

  function automatic base_t base_nb(base_t b, dir_e d);
    logic [NumDir*BaseW-1:0] row;
    base_t                   nb;
    case (b)
      base_t'(0):  row = {4'd1, 4'd3, 4'd4,  4'd5};
      base_t'(1):  row = {4'd2, 4'd0, 4'd5,  4'd6};
      base_t'(2):  row = {4'd3, 4'd1, 4'd6,  4'd7};
      base_t'(3):  row = {4'd0, 4'd2, 4'd7,  4'd4};
      base_t'(4):  row = {4'd0, 4'd3, 4'd11, 4'd8};
      base_t'(5):  row = {4'd1, 4'd0, 4'd8,  4'd9};
      base_t'(6):  row = {4'd2, 4'd1, 4'd9,  4'd10};
      base_t'(7):  row = {4'd3, 4'd2, 4'd10, 4'd11};
      base_t'(8):  row = {4'd5, 4'd4, 4'd11, 4'd9};
      base_t'(9):  row = {4'd6, 4'd5, 4'd8,  4'd10};
      base_t'(10): row = {4'd7, 4'd6, 4'd9,  4'd11};
      base_t'(11): row = {4'd4, 4'd7, 4'd10, 4'd8};
      default:     row = '0;
    endcase
    unique case (d)
      DirNe:   nb = row[3*BaseW +: BaseW];
      DirNw:   nb = row[2*BaseW +: BaseW];
      DirSw:   nb = row[1*BaseW +: BaseW];
      DirSe:   nb = row[0 +: BaseW];
      default: nb = '0;
    endcase
    return nb;
  endfunction

endpackage

FILE: rtl/hpn_unpack.sv
// stage 1: split the nested index into base patch and de-interleaved x, y
module hpn_unpack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hpn_pkg::ctl_t   ctl_i,
  input  hpn_pkg::idx_t   idx_i,
  output hpn_pkg::ctl_t   ctl_o,
  output hpn_pkg::base_t  base_o,
  output hpn_pkg::coord_t x_o,
  output hpn_pkg::coord_t y_o,
  output hpn_pkg::coord_t mask_o
);
  import hpn_pkg::*;

  logic [ShW-1:0] sh;
  idx_t           shifted;
  logic           lvl_bad;
  logic           base_bad;
  coord_t         mask_d;
  coord_t         xe;
  coord_t         yo;
  ctl_t           ctl_d;
  ctl_t           ctl_q;
  base_t          base_q;
  coord_t         x_q;
  coord_t         y_q;
  coord_t         mask_q;

  always_comb begin
    sh       = {ctl_i.level, 1'b0};
    shifted  = idx_i >> sh;
    lvl_bad  = ctl_i.level > lvl_t'(MaxLevel);
    base_bad = (|shifted[IdxW-1:BaseW]) || (shifted[BaseW-1:0] > LastBase);
    mask_d   = coord_t'(((CoordW+1)'(1) << ctl_i.level) - (CoordW+1)'(1));
    for (int k = 0; k < CoordW; k++) begin
      xe[k] = idx_i[2*k];
      yo[k] = idx_i[2*k+1];
    end
    ctl_d         = ctl_i;
    ctl_d.invalid = lvl_bad || base_bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= shifted[BaseW-1:0];
    x_q    <= xe & mask_d;
    y_q    <= yo & mask_d;
    mask_q <= mask_d;
  end

  assign ctl_o  = ctl_q;
  assign base_o = base_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign mask_o = mask_q;

endmodule

FILE: rtl/hpn_step.sv
// stage 2: one step in each direction with base-patch crossing and remap
module hpn_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hpn_pkg::ctl_t   ctl_i,
  input  hpn_pkg::base_t  base_i,
  input  hpn_pkg::coord_t x_i,
  input  hpn_pkg::coord_t y_i,
  input  hpn_pkg::coord_t mask_i,
  output hpn_pkg::ctl_t   ctl_o,
  output hpn_pkg::coord_t nx_o [hpn_pkg::NumDir],
  output hpn_pkg::coord_t ny_o [hpn_pkg::NumDir],
  output hpn_pkg::base_t  nb_o [hpn_pkg::NumDir]
);
  import hpn_pkg::*;

  logic   north;
  logic   south;
  coord_t nx_d [NumDir];
  coord_t ny_d [NumDir];
  base_t  nb_d [NumDir];
  ctl_t   ctl_q;
  coord_t nx_q [NumDir];
  coord_t ny_q [NumDir];
  base_t  nb_q [NumDir];

  always_comb begin
    north = base_i <= LastNorth;
    south = base_i >= FirstSouth;

    // +x
    nb_d[DirNe] = base_i;
    nx_d[DirNe] = x_i + coord_t'(1);
    ny_d[DirNe] = y_i;
    if (x_i == mask_i) begin
      nb_d[DirNe] = base_nb(base_i, DirNe);
      if (north) begin
        nx_d[DirNe] = y_i;
        ny_d[DirNe] = mask_i;
      end else begin
        nx_d[DirNe] = '0;
      end
    end

    // +y
    nb_d[DirNw] = base_i;
    nx_d[DirNw] = x_i;
    ny_d[DirNw] = y_i + coord_t'(1);
    if (y_i == mask_i) begin
      nb_d[DirNw] = base_nb(base_i, DirNw);
      if (north) begin
        ny_d[DirNw] = x_i;
        nx_d[DirNw] = mask_i;
      end else begin
        ny_d[DirNw] = '0;
      end
    end

    // -x
    nb_d[DirSw] = base_i;
    nx_d[DirSw] = x_i - coord_t'(1);
    ny_d[DirSw] = y_i;
    if (x_i == '0) begin
      nb_d[DirSw] = base_nb(base_i, DirSw);
      if (south) begin
        nx_d[DirSw] = y_i;
        ny_d[DirSw] = '0;
      end else begin
        nx_d[DirSw] = mask_i;
      end
    end

    // -y
    nb_d[DirSe] = base_i;
    nx_d[DirSe] = x_i;
    ny_d[DirSe] = y_i - coord_t'(1);
    if (y_i == '0) begin
      nb_d[DirSe] = base_nb(base_i, DirSe);
      if (south) begin
        ny_d[DirSe] = x_i;
        nx_d[DirSe] = '0;
      end else begin
        ny_d[DirSe] = mask_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
    ny_q <= ny_d;
    nb_q <= nb_d;
  end

  assign ctl_o = ctl_q;
  assign nx_o  = nx_q;
  assign ny_o  = ny_q;
  assign nb_o  = nb_q;

endmodule

FILE: rtl/hpn_pack.sv
// stage 3: re-interleave coordinates and place the base patch above them
module hpn_pack (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hpn_pkg::ctl_t   ctl_i,
  input  hpn_pkg::coord_t nx_i [hpn_pkg::NumDir],
  input  hpn_pkg::coord_t ny_i [hpn_pkg::NumDir],
  input  hpn_pkg::base_t  nb_i [hpn_pkg::NumDir],
  output logic            done_o,
  output logic            invalid_o,
  output hpn_pkg::idx_t   nbr_o [hpn_pkg::NumDir]
);
  import hpn_pkg::*;

  logic [ShW-1:0] sh;
  idx_t           nbr_d [NumDir];
  logic [2*CoordW-1:0] woven [NumDir];
  logic           done_q;
  logic           invalid_q;
  idx_t           nbr_q [NumDir];

  always_comb begin
    sh = {ctl_i.level, 1'b0};
    for (int d = 0; d < NumDir; d++) begin
      for (int k = 0; k < CoordW; k++) begin
        woven[d][2*k]   = nx_i[d][k];
        woven[d][2*k+1] = ny_i[d][k];
      end
      if (ctl_i.invalid) begin
        nbr_d[d] = '0;
      end else begin
        nbr_d[d] = (idx_t'(nb_i[d]) << sh) | idx_t'(woven[d]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      invalid_q <= 1'b0;
    end else begin
      done_q    <= ctl_i.valid;
      invalid_q <= ctl_i.invalid;
    end
  end

  always_ff @(posedge clk_i) begin
    nbr_q <= nbr_d;
  end

  assign done_o    = done_q;
  assign invalid_o = invalid_q;
  assign nbr_o     = nbr_q;

endmodule

FILE: rtl/healpix_nested_neighbour_index.sv
// top level of the nested sphere-tiling neighbour index pipeline
//
//  channel   ports                                          handshake
//  request   level_i, patch_index_i                         start_i, busy_o
//  result    north_east_o, north_west_o, south_west_o,      done_o (one-cycle strobe)
//            south_east_o, invalid_o
//
// four register stages: input capture, unpack (shift out base patch and
// de-interleave x, y), step (four directions with base-patch remap), pack
// (re-interleave and place base patch); each request passes through these
// stages in order, one beat per cycle sustained
// busy_o is held low: no stage ever waits, as results cannot be stalled
// reset clears only the control bits (valid, invalid, level); payload registers are left as they are
module healpix_nested_neighbour_index (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  hpn_pkg::lvl_t level_i,
  input  hpn_pkg::idx_t patch_index_i,
  output logic          done_o,
  output hpn_pkg::idx_t north_east_o,
  output hpn_pkg::idx_t north_west_o,
  output hpn_pkg::idx_t south_west_o,
  output hpn_pkg::idx_t south_east_o,
  output logic          invalid_o
);
  import hpn_pkg::*;

  // input capture stage
  ctl_t   in_ctl_d;
  ctl_t   in_ctl_q;
  idx_t   in_idx_q;

  // unpack stage outputs
  ctl_t   up_ctl;
  base_t  up_base;
  coord_t up_x;
  coord_t up_y;
  coord_t up_mask;

  // step stage outputs
  ctl_t   st_ctl;
  coord_t st_nx [NumDir];
  coord_t st_ny [NumDir];
  base_t  st_nb [NumDir];

  idx_t   nbr [NumDir];

  assign busy_o = 1'b0;

  always_comb begin
    in_ctl_d         = '0;
    in_ctl_d.valid   = start_i && !busy_o;
    in_ctl_d.level   = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else begin
      in_ctl_q <= in_ctl_d;
    end
  end

  // index register takes every cycle; the valid bit says whether it counts
  always_ff @(posedge clk_i) begin
    in_idx_q <= patch_index_i;
  end

  hpn_unpack u_unpack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (in_ctl_q),
    .idx_i  (in_idx_q),
    .ctl_o  (up_ctl),
    .base_o (up_base),
    .x_o    (up_x),
    .y_o    (up_y),
    .mask_o (up_mask)
  );

  hpn_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (up_ctl),
    .base_i (up_base),
    .x_i    (up_x),
    .y_i    (up_y),
    .mask_i (up_mask),
    .ctl_o  (st_ctl),
    .nx_o   (st_nx),
    .ny_o   (st_ny),
    .nb_o   (st_nb)
  );

  hpn_pack u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (st_ctl),
    .nx_i      (st_nx),
    .ny_i      (st_ny),
    .nb_i      (st_nb),
    .done_o    (done_o),
    .invalid_o (invalid_o),
    .nbr_o     (nbr)
  );

  assign north_east_o = nbr[DirNe];
  assign north_west_o = nbr[DirNw];
  assign south_west_o = nbr[DirSw];
  assign south_east_o = nbr[DirSe];

  // every request beat yields a result strobe on done_o
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result strobe missing four cycles after request");

  // a rejected request reports all neighbours as zero
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_o) |->
      (north_east_o == '0 && north_west_o == '0 &&
       south_west_o == '0 && south_east_o == '0))
    else $error("invalid result carries non-zero neighbours");

  // valid bit moves from unpack to step stage without loss
  a_stage_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_ctl.valid |=> st_ctl.valid)
    else $error("valid bit lost between unpack and step stages");

endmodule
